/* rtl/core/rast_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rast_pkg
// shared item types, opcodes and helpers for the range add / sum / max tree
// ---------------------------------------------------------------------------
package rast_pkg;

    localparam int unsigned IDX_FW  = 11;
    localparam int unsigned DATA_W  = 32;

    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_BUILD = 3'd1;
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_SUM   = 3'd3;
    localparam logic [2:0] OP_MAX   = 3'd4;

    localparam logic KIND_SUM = 1'b0;
    localparam logic KIND_MAX = 1'b1;

    localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [IDX_FW-1:0] COUNT_RESET = 11'd1024;

    typedef struct packed {
        logic [2:0]               opcode;
        logic [IDX_FW-1:0]        index_low;
        logic [IDX_FW-1:0]        index_high;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     result_kind;
    } t_out_item;

    typedef struct packed {
        logic sum;
        logic max;
        logic pend;
    } t_node_we;

    function automatic logic [DATA_W-1:0] smax(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
        return ($signed(a) >= $signed(b)) ? a : b;
    endfunction

endpackage

/* rtl/core/rast_node_store.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rast_node_store
// per-node sum, max and pending add memories, one write and one read port
// ---------------------------------------------------------------------------
module rast_node_store import rast_pkg::*; #(
    parameter int unsigned NODE_D = 4096
) (
    input  logic                      i_clk,
    input  t_node_we                  i_we,
    input  logic [$clog2(NODE_D)-1:0] i_waddr,
    input  logic [DATA_W-1:0]         i_wsum,
    input  logic [DATA_W-1:0]         i_wmax,
    input  logic [DATA_W-1:0]         i_wpend,
    input  logic [$clog2(NODE_D)-1:0] i_raddr,
    output logic [DATA_W-1:0]         o_rsum,
    output logic [DATA_W-1:0]         o_rmax,
    output logic [DATA_W-1:0]         o_rpend
);

    logic [DATA_W-1:0] r_sum_mem  [NODE_D];
    logic [DATA_W-1:0] r_max_mem  [NODE_D];
    logic [DATA_W-1:0] r_pend_mem [NODE_D];

    always_ff @(posedge i_clk) begin
        if (i_we.sum) begin
            r_sum_mem[i_waddr] <= i_wsum;
        end
        o_rsum <= r_sum_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.max) begin
            r_max_mem[i_waddr] <= i_wmax;
        end
        o_rmax <= r_max_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.pend) begin
            r_pend_mem[i_waddr] <= i_wpend;
        end
        o_rpend <= r_pend_mem[i_raddr];
    end

endmodule

/* rtl/core/range_add_sum_max_tree.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// range_add_sum_max_tree
// segment tree with lazy range add, range sum and range max queries
// ---------------------------------------------------------------------------
// usage:
//   in channel (i_in_valid / o_in_ready) takes one item: load, build, range
//   add, range sum or range max. out channel (o_out_valid / i_out_ready)
//   returns one result item for each sum or max query, nothing otherwise.
//   cfg channel (i_cfg_valid / o_cfg_ready) writes element_count, which is
//   sampled only by a build.
//   a build walks every tree node. adds and queries walk the nodes touched by
//   the range (up to about 4 per level) one at a time through the node
//   store's one read port, pushing lazy adds down on the way; adds and
//   builds also pull parents up. the node store read latency and the
//   one-read-per-cycle port set the pace; one item is in flight at a time.
//   after reset the leaf store is cleared, one entry per cycle, before the
//   first item is taken; config writes are taken during that time. queries
//   before any build answer as empty. a result waits in the output register;
//   the block keeps accepting items and only waits at the end of the next
//   query while that register is full.
// ---------------------------------------------------------------------------
module range_add_sum_max_tree import rast_pkg::*; #(
    parameter int unsigned MAX_ELEMENTS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_FW-1:0] i_cfg_data
);

    localparam int unsigned LEAF_W = $clog2(MAX_ELEMENTS);
    localparam int unsigned IDX_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned QW     = (IDX_W > IDX_FW) ? IDX_W : IDX_FW;
    localparam int unsigned NODE_D = 4 * MAX_ELEMENTS;
    localparam int unsigned NODE_W = $clog2(NODE_D);
    localparam int unsigned STK_D  = $clog2(MAX_ELEMENTS) + 2;
    localparam int unsigned SK_W   = $clog2(STK_D);
    localparam int unsigned SP_W   = SK_W + 1;

    typedef enum logic [15:0] {
        S_CLEAR    = 16'h0001,
        S_IDLE     = 16'h0002,
        S_ENTER    = 16'h0004,
        S_LEAF     = 16'h0008,
        S_QRY      = 16'h0010,
        S_PUSH_CHK = 16'h0020,
        S_APPLY_A  = 16'h0040,
        S_APPLY_B  = 16'h0080,
        S_PUSH_CLR = 16'h0100,
        S_DESCEND  = 16'h0200,
        S_RETURN   = 16'h0400,
        S_PULL_A   = 16'h0800,
        S_PULL_B   = 16'h1000,
        S_PULL_C   = 16'h2000,
        S_DONE     = 16'h4000
    } t_state;

    typedef enum logic [1:0] {
        RET_POP    = 2'd0,
        RET_PUSH_R = 2'd1,
        RET_PUSH_C = 2'd2
    } t_ret;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [QW-1:0]     lo;
        logic [QW-1:0]     hi;
        logic              right;
    } t_frame;

    t_state r_state, n_state;

    logic [IDX_FW-1:0] r_count;
    logic [QW-1:0]     r_built;
    logic [LEAF_W-1:0] r_clr;

    logic [2:0]        r_op;
    logic [QW-1:0]     r_l;
    logic [QW-1:0]     r_r;
    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] r_acc;

    logic [NODE_W-1:0] r_node;
    logic [QW-1:0]     r_lo;
    logic [QW-1:0]     r_hi;

    logic [NODE_W-1:0] r_ap_node;
    logic [QW-1:0]     r_ap_len;
    logic [DATA_W-1:0] r_ap_c;
    logic [DATA_W-1:0] r_prod;
    t_ret              r_ap_ret;

    logic [DATA_W-1:0] r_a_sum;
    logic [DATA_W-1:0] r_a_max;

    t_frame            r_stk [STK_D];
    logic [SP_W-1:0]   r_sp;

    logic              r_out_valid;
    t_out_item         r_out_item;

    logic [DATA_W-1:0] r_leaf_mem [MAX_ELEMENTS];
    logic [DATA_W-1:0] r_leaf_q;

    // node store ports
    t_node_we          w_we;
    logic [NODE_W-1:0] w_waddr;
    logic [NODE_W-1:0] w_raddr;
    logic [DATA_W-1:0] w_wsum;
    logic [DATA_W-1:0] w_wmax;
    logic [DATA_W-1:0] w_wpend;
    logic [DATA_W-1:0] w_rsum;
    logic [DATA_W-1:0] w_rmax;
    logic [DATA_W-1:0] w_rpend;

    logic              w_accept;
    logic [QW-1:0]     w_in_lo;
    logic [QW-1:0]     w_in_hi;
    logic [QW-1:0]     w_clip_l;
    logic [QW-1:0]     w_clip_r;
    logic              w_empty;
    logic [QW-1:0]     w_cnt;
    logic [QW-1:0]     w_build_n;
    logic              w_load_ok;
    logic [QW-1:0]     w_load_idx;

    logic [QW:0]       w_mid_sum;
    logic [QW-1:0]     w_mid;
    logic              w_covered;
    logic              w_is_query;
    logic              w_is_build;
    logic [NODE_W-1:0] w_lc;
    logic [NODE_W-1:0] w_rc;
    logic [QW-1:0]     w_leaf_idx;

    logic [SP_W-1:0]   w_sp_m1;
    logic [SK_W-1:0]   w_top_idx;
    t_frame            w_top;
    logic [QW:0]       w_top_mid_sum;
    logic [QW-1:0]     w_top_mid;
    logic              w_top_right;
    logic [NODE_W-1:0] w_top_rc;
    logic              w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_lo    = QW'(i_in_item.index_low);
    assign w_in_hi    = QW'(i_in_item.index_high);
    assign w_clip_l   = (w_in_lo == '0) ? QW'(1) : w_in_lo;
    assign w_clip_r   = (w_in_hi > r_built) ? r_built : w_in_hi;
    assign w_empty    = (r_built == '0) || (w_clip_l > w_clip_r);
    assign w_cnt      = QW'(r_count);
    assign w_build_n  = (w_cnt == '0) ? QW'(1) :
                        (w_cnt > QW'(MAX_ELEMENTS)) ? QW'(MAX_ELEMENTS) : w_cnt;
    assign w_load_ok  = (w_in_lo != '0) && (w_in_lo <= QW'(MAX_ELEMENTS));
    assign w_load_idx = w_in_lo - QW'(1);

    assign w_mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_mid_sum[QW:1];
    assign w_covered  = (r_l <= r_lo) && (r_hi <= r_r);
    assign w_is_query = (r_op == OP_SUM) || (r_op == OP_MAX);
    assign w_is_build = (r_op == OP_BUILD);
    assign w_lc       = {r_node[NODE_W-2:0], 1'b0};
    assign w_rc       = {r_node[NODE_W-2:0], 1'b1};
    assign w_leaf_idx = r_lo - QW'(1);

    assign w_sp_m1       = r_sp - SP_W'(1);
    assign w_top_idx     = w_sp_m1[SK_W-1:0];
    assign w_top         = r_stk[w_top_idx];
    assign w_top_mid_sum = {1'b0, w_top.lo} + {1'b0, w_top.hi};
    assign w_top_mid     = w_top_mid_sum[QW:1];
    assign w_top_right   = w_is_build || (r_r > w_top_mid);
    assign w_top_rc      = {w_top.node[NODE_W-2:0], 1'b1};
    assign w_out_free    = !r_out_valid || i_out_ready;

    // leaf store: cleared after reset, written by loads, read by builds
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_leaf_mem[r_clr] <= '0;
        end else if (w_accept && (i_in_item.opcode == OP_LOAD) && w_load_ok) begin
            r_leaf_mem[w_load_idx[LEAF_W-1:0]] <= i_in_item.value;
        end
        r_leaf_q <= r_leaf_mem[w_leaf_idx[LEAF_W-1:0]];
    end

    rast_node_store #(
        .NODE_D (NODE_D)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wsum  (w_wsum),
        .i_wmax  (w_wmax),
        .i_wpend (w_wpend),
        .i_raddr (w_raddr),
        .o_rsum  (w_rsum),
        .o_rmax  (w_rmax),
        .o_rpend (w_rpend)
    );

    always_comb begin
        w_we    = '0;
        w_waddr = r_node;
        w_wsum  = r_leaf_q;
        w_wmax  = r_leaf_q;
        w_wpend = '0;
        w_raddr = r_node;
        unique case (r_state)
            S_ENTER: begin
                if (w_is_build) begin
                    w_we.pend = 1'b1;
                end
            end
            S_LEAF: begin
                w_we.sum = 1'b1;
                w_we.max = 1'b1;
            end
            S_APPLY_A: begin
                w_raddr = r_ap_node;
            end
            S_APPLY_B: begin
                w_we    = '{sum: 1'b1, max: 1'b1, pend: 1'b1};
                w_waddr = r_ap_node;
                w_wsum  = w_rsum + r_prod;
                w_wmax  = w_rmax + r_ap_c;
                w_wpend = w_rpend + r_ap_c;
            end
            S_PUSH_CLR: begin
                w_we.pend = 1'b1;
            end
            S_PULL_A: begin
                w_raddr = w_lc;
            end
            S_PULL_B: begin
                w_raddr = w_rc;
            end
            S_PULL_C: begin
                w_we.sum = 1'b1;
                w_we.max = 1'b1;
                w_wsum   = r_a_sum + w_rsum;
                w_wmax   = smax(r_a_max, w_rmax);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == LEAF_W'(MAX_ELEMENTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_item.opcode) inside
                        OP_BUILD: n_state = S_ENTER;
                        OP_ADD:   n_state = w_empty ? S_IDLE : S_ENTER;
                        OP_SUM, OP_MAX: n_state = w_empty ? S_DONE : S_ENTER;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ENTER: begin
                if (w_is_build) begin
                    n_state = (r_lo == r_hi) ? S_LEAF : S_DESCEND;
                end else if (w_covered) begin
                    n_state = w_is_query ? S_QRY : S_APPLY_A;
                end else begin
                    n_state = S_PUSH_CHK;
                end
            end
            S_LEAF:     n_state = S_RETURN;
            S_QRY:      n_state = S_RETURN;
            S_PUSH_CHK: n_state = (w_rpend == '0) ? S_DESCEND : S_APPLY_A;
            S_APPLY_A:  n_state = S_APPLY_B;
            S_APPLY_B: begin
                case (r_ap_ret)
                    RET_PUSH_R: n_state = S_APPLY_A;
                    RET_PUSH_C: n_state = S_PUSH_CLR;
                    default:    n_state = S_RETURN;
                endcase
            end
            S_PUSH_CLR: n_state = S_DESCEND;
            S_DESCEND:  n_state = S_ENTER;
            S_RETURN: begin
                if (r_sp == '0) begin
                    n_state = w_is_query ? S_DONE : S_IDLE;
                end else if (!w_top.right && w_top_right) begin
                    n_state = S_ENTER;
                end else if (!w_is_query) begin
                    n_state = S_PULL_A;
                end
            end
            S_PULL_A:   n_state = S_PULL_B;
            S_PULL_B:   n_state = S_PULL_C;
            S_PULL_C:   n_state = S_RETURN;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_count     <= COUNT_RESET;
            r_built     <= '0;
            r_clr       <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + LEAF_W'(1);
            end
            if (w_accept && (i_in_item.opcode == OP_BUILD)) begin
                r_built <= w_build_n;
            end
            if (r_state == S_DESCEND) begin
                r_sp <= r_sp + SP_W'(1);
            end else if ((r_state == S_RETURN) && (r_sp != '0)
                         && !(!w_top.right && w_top_right)) begin
                r_sp <= w_sp_m1;
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op   <= i_in_item.opcode;
                r_l    <= w_clip_l;
                r_r    <= w_clip_r;
                r_val  <= i_in_item.value;
                r_acc  <= (i_in_item.opcode == OP_MAX) ? INT_MIN : '0;
                r_node <= NODE_W'(1);
                r_lo   <= QW'(1);
                r_hi   <= (i_in_item.opcode == OP_BUILD) ? w_build_n : r_built;
            end
            S_ENTER: begin
                r_ap_node <= r_node;
                r_ap_len  <= r_hi - r_lo + QW'(1);
                r_ap_c    <= r_val;
                r_ap_ret  <= RET_POP;
            end
            S_QRY: begin
                r_acc <= (r_op == OP_MAX) ? smax(r_acc, w_rmax) : r_acc + w_rsum;
            end
            S_PUSH_CHK: begin
                r_ap_node <= w_lc;
                r_ap_len  <= w_mid - r_lo + QW'(1);
                r_ap_c    <= w_rpend;
                r_ap_ret  <= RET_PUSH_R;
            end
            S_APPLY_A: begin
                r_prod <= DATA_W'(r_ap_len) * r_ap_c;
            end
            S_APPLY_B: begin
                if (r_ap_ret == RET_PUSH_R) begin
                    r_ap_node <= w_rc;
                    r_ap_len  <= r_hi - w_mid;
                    r_ap_ret  <= RET_PUSH_C;
                end
            end
            S_DESCEND: begin
                // left child first when it overlaps the range
                if (w_is_build || (r_l <= w_mid)) begin
                    r_stk[r_sp[SK_W-1:0]] <= '{node: r_node, lo: r_lo, hi: r_hi,
                                               right: 1'b0};
                    r_node <= w_lc;
                    r_hi   <= w_mid;
                end else begin
                    r_stk[r_sp[SK_W-1:0]] <= '{node: r_node, lo: r_lo, hi: r_hi,
                                               right: 1'b1};
                    r_node <= w_rc;
                    r_lo   <= w_mid + QW'(1);
                end
            end
            S_RETURN: begin
                if (r_sp != '0) begin
                    if (!w_top.right && w_top_right) begin
                        r_stk[w_top_idx].right <= 1'b1;
                        r_node <= w_top_rc;
                        r_lo   <= w_top_mid + QW'(1);
                        r_hi   <= w_top.hi;
                    end else begin
                        r_node <= w_top.node;
                        r_lo   <= w_top.lo;
                        r_hi   <= w_top.hi;
                    end
                end
            end
            S_PULL_B: begin
                r_a_sum <= w_rsum;
                r_a_max <= w_rmax;
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_item.result_value <= r_acc;
                    r_out_item.result_kind  <= (r_op == OP_MAX) ? KIND_MAX : KIND_SUM;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// checks the range add / sum / max tree against a lazy segment tree model:
// loads, builds, range adds and queries go in under random idling on both
// channels, and every sum or max answer is compared in order
// ---------------------------------------------------------------------------
module tb_top;
    import rast_pkg::*;

    localparam int unsigned MAX_EL = 1024;
    localparam int unsigned NODE_EL = 4 * MAX_EL;

    // same tree as the block, so wrapped maxima match bit for bit
    class tree_scoreboard;
        logic [31:0] leaves [1:MAX_EL];
        logic [31:0] node_sum [NODE_EL];
        logic [31:0] node_max [NODE_EL];
        logic [31:0] node_pend [NODE_EL];
        int unsigned built_n;
        int unsigned count_reg;
        t_out_item   answers [$];
        int          errors;

        function void reset_state();
            for (int i = 1; i <= MAX_EL; i++) begin
                leaves[i] = '0;
            end
            for (int i = 0; i < NODE_EL; i++) begin
                node_sum[i] = '0;
                node_max[i] = '0;
                node_pend[i] = '0;
            end
            built_n = 0;
            count_reg = MAX_EL;
            errors = 0;
            answers.delete();
        endfunction

        function logic [31:0] smax32(logic [31:0] a, logic [31:0] b);
            return ($signed(a) >= $signed(b)) ? a : b;
        endfunction

        function void apply_add(int unsigned node, int unsigned len, logic [31:0] c);
            if (node >= NODE_EL) return;
            node_sum[node] = node_sum[node] + 32'(len) * c;
            node_max[node] = node_max[node] + c;
            node_pend[node] = node_pend[node] + c;
        endfunction

        function void pull(int unsigned node);
            if (2 * node + 1 >= NODE_EL) return;
            node_sum[node] = node_sum[2 * node] + node_sum[2 * node + 1];
            node_max[node] = smax32(node_max[2 * node], node_max[2 * node + 1]);
        endfunction

        function void push(int unsigned node, int unsigned lo, int unsigned mid,
                           int unsigned hi);
            logic [31:0] c;
            if (node >= NODE_EL) return;
            c = node_pend[node];
            if (c == 0) return;
            apply_add(2 * node, mid - lo + 1, c);
            apply_add(2 * node + 1, hi - mid, c);
            node_pend[node] = '0;
        endfunction

        function void build_node(int unsigned lo, int unsigned hi, int unsigned node);
            int unsigned mid;
            if (node >= NODE_EL) return;
            node_pend[node] = '0;
            if (lo == hi) begin
                node_sum[node] = leaves[lo];
                node_max[node] = leaves[lo];
                return;
            end
            mid = (lo + hi) / 2;
            build_node(lo, mid, 2 * node);
            build_node(mid + 1, hi, 2 * node + 1);
            pull(node);
        endfunction

        function void add_range(int unsigned l, int unsigned r, logic [31:0] c,
                                int unsigned lo, int unsigned hi, int unsigned node);
            int unsigned mid;
            if (node >= NODE_EL) return;
            if (l <= lo && hi <= r) begin
                apply_add(node, hi - lo + 1, c);
                return;
            end
            mid = (lo + hi) / 2;
            push(node, lo, mid, hi);
            if (l <= mid) add_range(l, r, c, lo, mid, 2 * node);
            if (r > mid) add_range(l, r, c, mid + 1, hi, 2 * node + 1);
            pull(node);
        endfunction

        function logic [31:0] sum_range(int unsigned l, int unsigned r,
                                        int unsigned lo, int unsigned hi,
                                        int unsigned node);
            int unsigned mid;
            logic [31:0] acc;
            acc = '0;
            if (node >= NODE_EL) return '0;
            if (l <= lo && hi <= r) return node_sum[node];
            mid = (lo + hi) / 2;
            push(node, lo, mid, hi);
            if (l <= mid) acc = acc + sum_range(l, r, lo, mid, 2 * node);
            if (r > mid) acc = acc + sum_range(l, r, mid + 1, hi, 2 * node + 1);
            return acc;
        endfunction

        function logic [31:0] max_range(int unsigned l, int unsigned r,
                                        int unsigned lo, int unsigned hi,
                                        int unsigned node);
            int unsigned mid;
            logic [31:0] acc;
            acc = INT_MIN;
            if (node >= NODE_EL) return INT_MIN;
            if (l <= lo && hi <= r) return node_max[node];
            mid = (lo + hi) / 2;
            push(node, lo, mid, hi);
            if (l <= mid) acc = smax32(acc, max_range(l, r, lo, mid, 2 * node));
            if (r > mid) acc = smax32(acc, max_range(l, r, mid + 1, hi, 2 * node + 1));
            return acc;
        endfunction

        function void note_item(t_in_item it);
            int unsigned lo;
            int unsigned hi;
            bit          empty;
            t_out_item   ans;
            lo = (it.index_low < 1) ? 1 : it.index_low;
            hi = (it.index_high > built_n) ? built_n : it.index_high;
            empty = (built_n == 0) || (lo > hi);
            case (it.opcode)
                OP_LOAD: begin
                    if (it.index_low >= 1 && it.index_low <= MAX_EL)
                        leaves[it.index_low] = it.value;
                end
                OP_BUILD: begin
                    built_n = (count_reg < 1) ? 1 : (count_reg > MAX_EL) ? MAX_EL : count_reg;
                    for (int i = 0; i < NODE_EL; i++) node_pend[i] = '0;
                    build_node(1, built_n, 1);
                end
                OP_ADD: begin
                    if (!empty) add_range(lo, hi, it.value, 1, built_n, 1);
                end
                OP_SUM: begin
                    ans.result_value = empty ? 32'h0 : sum_range(lo, hi, 1, built_n, 1);
                    ans.result_kind = KIND_SUM;
                    answers.push_back(ans);
                end
                OP_MAX: begin
                    ans.result_value = empty ? INT_MIN : max_range(lo, hi, 1, built_n, 1);
                    ans.result_kind = KIND_MAX;
                    answers.push_back(ans);
                end
                default: ;
            endcase
        endfunction

        function void check_answer(t_out_item got);
            t_out_item want;
            if (answers.size() == 0) begin
                $display("%0t: unexpected result expected none actual %h/%0d",
                         $time, got.result_value, got.result_kind);
                errors++;
                return;
            end
            want = answers.pop_front();
            if (got.result_value !== want.result_value) begin
                $display("%0t: result_value expected %h actual %h",
                         $time, want.result_value, got.result_value);
                errors++;
            end
            if (got.result_kind !== want.result_kind) begin
                $display("%0t: result_kind expected %0d actual %0d",
                         $time, want.result_kind, got.result_kind);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic [IDX_FW-1:0] i_cfg_data;

    tree_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    bit  stim_done;

    range_add_sum_max_tree #(.MAX_ELEMENTS(MAX_EL)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) sb.check_answer(o_out_item);
            i_out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // valid stays up after an accept so items can go back to back
    task automatic send_item(t_in_item it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_item(it);
    endtask

    task automatic send_op(logic [2:0] op, int unsigned lo, int unsigned hi,
                           logic [31:0] val);
        t_in_item it;
        it.opcode = op;
        it.index_low = lo[IDX_FW-1:0];
        it.index_high = hi[IDX_FW-1:0];
        it.value = val;
        send_item(it);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (sb.answers.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        // a build or add may still be walking the tree
        repeat (12000) @(posedge i_clk);
    endtask

    task automatic write_count(int unsigned n);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= n[IDX_FW-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.count_reg = n[IDX_FW-1:0];
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // mostly valid ranges inside the built count, sometimes anything at all
    task automatic random_op(int unsigned n);
        int unsigned lo;
        int unsigned hi;
        int unsigned pick;
        pick = $urandom_range(99);
        if ($urandom_range(9) == 0) begin
            lo = $urandom_range(2047);
            hi = $urandom_range(2047);
        end else begin
            lo = $urandom_range(n, 1);
            hi = $urandom_range(n, lo);
        end
        if (pick < 15)      send_op(OP_LOAD, $urandom_range(n + 1, 0), 0, rand_value());
        else if (pick < 18) send_op(OP_BUILD, lo, hi, $urandom);
        else if (pick < 45) send_op(OP_ADD, lo, hi, rand_value());
        else if (pick < 70) send_op(OP_SUM, lo, hi, $urandom);
        else if (pick < 95) send_op(OP_MAX, lo, hi, $urandom);
        else                send_op(3'($urandom_range(7, 5)), lo, hi, $urandom);
    endtask

    task automatic random_phase(int unsigned n, int items);
        write_count(n);
        for (int i = 1; i <= n && i <= 16; i++) send_op(OP_LOAD, i, 0, rand_value());
        send_op(OP_BUILD, 0, 0, 0);
        for (int i = 0; i < items; i++) random_op(n);
        drain();
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        hold_off = 1'b0;
        stim_done = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: queries and add before any build, extremes, bad codes
        send_op(OP_SUM, 1, 5, 0);
        send_op(OP_MAX, 1, 5, 0);
        send_op(OP_ADD, 1, 5, 7);
        send_op(OP_LOAD, 0, 0, 32'h1234_5678);
        send_op(OP_LOAD, 1025, 0, 32'h1234_5678);
        send_op(OP_LOAD, 1, 0, 32'h7fff_ffff);
        send_op(OP_LOAD, 2, 0, 32'h7fff_ffff);
        send_op(OP_LOAD, 3, 0, 32'h8000_0000);
        send_op(OP_LOAD, 1024, 0, 32'hffff_ffff);
        drain();
        write_count(0);
        send_op(OP_BUILD, 0, 0, 0);
        send_op(OP_SUM, 0, 2047, 0);
        drain();
        write_count(4);
        send_op(OP_BUILD, 0, 0, 0);
        send_op(OP_SUM, 1, 3, 0);
        send_op(OP_MAX, 0, 2047, 0);
        send_op(OP_SUM, 3, 2, 0);
        send_op(OP_MAX, 3, 2, 0);
        send_op(OP_ADD, 2, 4, 32'h8000_0000);
        send_op(OP_MAX, 1, 4, 0);
        send_op(OP_LOAD, 2, 0, 5);
        send_op(OP_SUM, 1, 4, 0);
        send_op(3'd5, 1, 4, 0);
        send_op(3'd7, 1, 4, 0);
        drain();
        write_count(2047);
        send_op(OP_BUILD, 0, 0, 0);
        send_op(OP_ADD, 1, 2047, 3);
        send_op(OP_SUM, 1, 1024, 0);
        send_op(OP_MAX, 1000, 1024, 0);
        drain();

        send_idle_pct = 11;
        recv_idle_pct = 78;
        random_phase(8, 120);
        // long receiver hold-off while items keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 12; i++) send_op(OP_SUM, 1, 8, 0);
                i_in_valid <= 1'b0;
            end
        join
        drain();
        send_idle_pct = 78;
        recv_idle_pct = 11;
        random_phase(37, 120);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(1024, 40);
        random_phase(1, 60);
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.answers.size() == 0) begin
            $display("range_add_sum_max_tree test passed");
        end else begin
            $display("range_add_sum_max_tree test failed");
        end
        $finish;
    end

    initial begin
        #80ms;
        $display("range_add_sum_max_tree test failed");
        $finish;
    end
endmodule

/* files.f */
rtl/core/rast_pkg.sv
rtl/core/rast_node_store.sv
rtl/core/range_add_sum_max_tree.sv
tb/tb_top.sv
